@@ rtl/c6502eu_pkg.sv @@
// Shared types, operation codes and helpers for the 6502 execute unit.
// No dependencies.
package c6502eu_pkg;

	localparam int unsigned STACK_DEPTH = 256;
	localparam int unsigned STACK_AW    = $clog2(STACK_DEPTH);

	// status bit positions
	localparam int unsigned FL_C = 0;
	localparam int unsigned FL_Z = 1;
	localparam int unsigned FL_I = 2;
	localparam int unsigned FL_D = 3;
	localparam int unsigned FL_B = 4;
	localparam int unsigned FL_U = 5;
	localparam int unsigned FL_V = 6;
	localparam int unsigned FL_N = 7;

	localparam logic [7:0] FLAGS_RESET = 8'h20;
	localparam logic [7:0] SP_RESET    = 8'hFD;
	localparam logic [7:0] PUSH_BU     = 8'h30;

	localparam logic [5:0] OP_ADC = 6'd0;
	localparam logic [5:0] OP_SBC = 6'd1;
	localparam logic [5:0] OP_AND = 6'd2;
	localparam logic [5:0] OP_EOR = 6'd3;
	localparam logic [5:0] OP_ORA = 6'd4;
	localparam logic [5:0] OP_BIT = 6'd5;
	localparam logic [5:0] OP_ASL = 6'd6;
	localparam logic [5:0] OP_LSR = 6'd7;
	localparam logic [5:0] OP_ROL = 6'd8;
	localparam logic [5:0] OP_ROR = 6'd9;
	localparam logic [5:0] OP_CMP = 6'd10;
	localparam logic [5:0] OP_CPX = 6'd11;
	localparam logic [5:0] OP_CPY = 6'd12;
	localparam logic [5:0] OP_LDA = 6'd13;
	localparam logic [5:0] OP_LDX = 6'd14;
	localparam logic [5:0] OP_LDY = 6'd15;
	localparam logic [5:0] OP_STA = 6'd16;
	localparam logic [5:0] OP_STX = 6'd17;
	localparam logic [5:0] OP_STY = 6'd18;
	localparam logic [5:0] OP_TAX = 6'd19;
	localparam logic [5:0] OP_TXA = 6'd20;
	localparam logic [5:0] OP_TAY = 6'd21;
	localparam logic [5:0] OP_TYA = 6'd22;
	localparam logic [5:0] OP_TSX = 6'd23;
	localparam logic [5:0] OP_TXS = 6'd24;
	localparam logic [5:0] OP_INC = 6'd25;
	localparam logic [5:0] OP_DEC = 6'd26;
	localparam logic [5:0] OP_INX = 6'd27;
	localparam logic [5:0] OP_DEX = 6'd28;
	localparam logic [5:0] OP_INY = 6'd29;
	localparam logic [5:0] OP_DEY = 6'd30;
	localparam logic [5:0] OP_BCS = 6'd31;
	localparam logic [5:0] OP_BCC = 6'd32;
	localparam logic [5:0] OP_BEQ = 6'd33;
	localparam logic [5:0] OP_BNE = 6'd34;
	localparam logic [5:0] OP_BMI = 6'd35;
	localparam logic [5:0] OP_BPL = 6'd36;
	localparam logic [5:0] OP_BVS = 6'd37;
	localparam logic [5:0] OP_BVC = 6'd38;
	localparam logic [5:0] OP_JMP = 6'd39;
	localparam logic [5:0] OP_JSR = 6'd40;
	localparam logic [5:0] OP_RTS = 6'd41;
	localparam logic [5:0] OP_PHA = 6'd42;
	localparam logic [5:0] OP_PHP = 6'd43;
	localparam logic [5:0] OP_PLA = 6'd44;
	localparam logic [5:0] OP_PLP = 6'd45;
	localparam logic [5:0] OP_CLC = 6'd46;
	localparam logic [5:0] OP_CLD = 6'd47;
	localparam logic [5:0] OP_CLI = 6'd48;
	localparam logic [5:0] OP_CLV = 6'd49;
	localparam logic [5:0] OP_SEC = 6'd50;
	localparam logic [5:0] OP_SED = 6'd51;
	localparam logic [5:0] OP_SEI = 6'd52;
	localparam logic [5:0] OP_BRK = 6'd53;
	localparam logic [5:0] OP_RTI = 6'd54;
	localparam logic [5:0] OP_NOP = 6'd55;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PUSH = 3'b010,
		ST_PULL = 3'b100
	} seq_state_t;

	typedef struct packed {
		logic        we;
		logic [15:0] wa;
		logic [7:0]  wd;
		logic [15:0] pc;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  p;
		logic [7:0]  s;
		logic [1:0]  extra;
		logic        hint;
	} result_t;

	function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] r;
		r       = p;
		r[FL_Z] = (v == 8'h00);
		r[FL_N] = v[7];
		return r;
	endfunction

endpackage

@@ rtl/c6502eu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c6502eu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/cpu6502_execute_unit.sv @@
// 6502 execute unit top level: register file, stack sequencer, output stage.
// Depends on c6502eu_pkg and c6502eu_ram.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------
//  input     | in_valid / in_stall        | op operand effective_addr
//            |                            | branch_offset implied_mode raw_opcode
//            |                            | next_pc
//  output    | out_valid / out_stall      | write_* new_pc *_out extra_cycles
//            |                            | may_add_cycle
//  config    | irq_vector_we              | irq_vector_wdata
//
// Non-stack words execute in the accept cycle: one word per cycle while
// in_stall is low. PHA/PHP push one byte, JSR two, BRK three (one write per
// cycle); PLA/PLP pull one, RTS two, RTI three (one registered read per cycle).
// Reset clears A/X/Y, status to 0x20, SP to 0xFD and the per-entry valid bits
// of the stack page, so unwritten entries read as zero. A word is taken while
// the sequencer is idle and the output word is being taken or is empty.

module cpu6502_execute_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [5:0]  op,
	input  logic [7:0]  operand,
	input  logic [15:0] effective_addr,
	input  logic [15:0] branch_offset,
	input  logic        implied_mode,
	input  logic [7:0]  raw_opcode,
	input  logic [15:0] next_pc,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_enable,
	output logic [15:0] write_addr,
	output logic [7:0]  write_data,
	output logic [15:0] new_pc,
	output logic [7:0]  accumulator_out,
	output logic [7:0]  index_x_out,
	output logic [7:0]  index_y_out,
	output logic [7:0]  status_out,
	output logic [7:0]  stack_ptr_out,
	output logic [1:0]  extra_cycles,
	output logic        may_add_cycle,

	input  logic        irq_vector_we,
	input  logic [15:0] irq_vector_wdata
);

	// architectural registers
	logic [7:0]  a_q, x_q, y_q, p_q, s_q;
	logic [15:0] irq_q;

	// sequencer
	c6502eu_pkg::seq_state_t state_q;
	logic [1:0]  step_q;
	logic [1:0]  nacc_q;
	logic [5:0]  op_q;
	logic [15:0] ea_q, pc_q;
	logic [7:0]  b0_q, b1_q;

	// output stage
	logic                  ovalid_q;
	c6502eu_pkg::result_t  out_q;

	// stack store
	localparam int unsigned STK_AW_L = c6502eu_pkg::STACK_AW;
	logic [STK_AW_L-1:0] ram_waddr, ram_raddr;
	logic        ram_we;
	logic [7:0]  ram_wdata, ram_rdata;
	logic [c6502eu_pkg::STACK_DEPTH-1:0] vld_q;
	logic        rvld_q;
	logic [7:0]  rd_byte;

	logic        out_free, in_acc, in_is_stack, in_is_push, ram_re;
	logic [1:0]  in_nacc;
	logic        fin;
	c6502eu_pkg::result_t ex_res, st_res, load_res;
	logic        load;

	assign out_free = !ovalid_q || !out_stall;
	assign in_stall = (state_q != c6502eu_pkg::ST_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	// classify stack words
	always_comb begin
		in_is_stack = 1'b1;
		in_is_push  = 1'b0;
		in_nacc     = 2'd1;
		case (op)
			c6502eu_pkg::OP_PHA, c6502eu_pkg::OP_PHP: in_is_push = 1'b1;
			c6502eu_pkg::OP_JSR: begin
				in_is_push = 1'b1;
				in_nacc    = 2'd2;
			end
			c6502eu_pkg::OP_BRK: begin
				in_is_push = 1'b1;
				in_nacc    = 2'd3;
			end
			c6502eu_pkg::OP_PLA, c6502eu_pkg::OP_PLP: in_nacc = 2'd1;
			c6502eu_pkg::OP_RTS: in_nacc = 2'd2;
			c6502eu_pkg::OP_RTI: in_nacc = 2'd3;
			default: in_is_stack = 1'b0;
		endcase
	end

	// combinational execution of everything that leaves the stack alone
	always_comb begin
		logic [7:0] m, v, r;
		logic [8:0] t;
		logic [15:0] dest;
		logic take, br;
		m    = implied_mode ? a_q : operand;
		v    = (op == c6502eu_pkg::OP_SBC) ? ~m : m;
		t    = {1'b0, a_q} + {1'b0, v} + {8'd0, p_q[c6502eu_pkg::FL_C]};
		r    = 8'h00;
		take = 1'b0;
		br   = 1'b0;
		dest = next_pc + branch_offset;
		ex_res       = '0;
		ex_res.pc    = next_pc;
		ex_res.a     = a_q;
		ex_res.x     = x_q;
		ex_res.y     = y_q;
		ex_res.p     = p_q;
		ex_res.s     = s_q;
		case (op)
			c6502eu_pkg::OP_ADC, c6502eu_pkg::OP_SBC: begin
				ex_res.p[c6502eu_pkg::FL_C] = t[8];
				ex_res.p[c6502eu_pkg::FL_V] = (t[7] ^ a_q[7]) & (t[7] ^ v[7]);
				ex_res.a = t[7:0];
				ex_res.p = c6502eu_pkg::set_nz(ex_res.p, t[7:0]);
				ex_res.hint = 1'b1;
			end
			c6502eu_pkg::OP_AND, c6502eu_pkg::OP_EOR, c6502eu_pkg::OP_ORA: begin
				if (op == c6502eu_pkg::OP_AND) begin
					r = a_q & m;
				end else if (op == c6502eu_pkg::OP_EOR) begin
					r = a_q ^ m;
				end else begin
					r = a_q | m;
				end
				ex_res.a    = r;
				ex_res.p    = c6502eu_pkg::set_nz(p_q, r);
				ex_res.hint = 1'b1;
			end
			c6502eu_pkg::OP_BIT: begin
				ex_res.p[c6502eu_pkg::FL_Z] = ((a_q & m) == 8'h00);
				ex_res.p[c6502eu_pkg::FL_N] = m[7];
				ex_res.p[c6502eu_pkg::FL_V] = m[6];
			end
			c6502eu_pkg::OP_ASL, c6502eu_pkg::OP_LSR,
			c6502eu_pkg::OP_ROL, c6502eu_pkg::OP_ROR: begin
				if (op == c6502eu_pkg::OP_ASL) begin
					r = {m[6:0], 1'b0};
				end else if (op == c6502eu_pkg::OP_LSR) begin
					r = {1'b0, m[7:1]};
				end else if (op == c6502eu_pkg::OP_ROL) begin
					r = {m[6:0], p_q[c6502eu_pkg::FL_C]};
				end else begin
					r = {p_q[c6502eu_pkg::FL_C], m[7:1]};
				end
				ex_res.p = c6502eu_pkg::set_nz(p_q, r);
				ex_res.p[c6502eu_pkg::FL_C] =
					(op == c6502eu_pkg::OP_ASL || op == c6502eu_pkg::OP_ROL) ? m[7] : m[0];
				if (implied_mode) begin
					ex_res.a = r;
				end else begin
					ex_res.we = 1'b1;
					ex_res.wd = r;
				end
			end
			c6502eu_pkg::OP_CMP, c6502eu_pkg::OP_CPX, c6502eu_pkg::OP_CPY: begin
				if (op == c6502eu_pkg::OP_CMP) begin
					r = a_q;
				end else if (op == c6502eu_pkg::OP_CPX) begin
					r = x_q;
				end else begin
					r = y_q;
				end
				ex_res.p = c6502eu_pkg::set_nz(p_q, r - m);
				ex_res.p[c6502eu_pkg::FL_C] = (r >= m);
				ex_res.hint = (op == c6502eu_pkg::OP_CMP);
			end
			c6502eu_pkg::OP_LDA: begin
				ex_res.a = m; ex_res.p = c6502eu_pkg::set_nz(p_q, m); ex_res.hint = 1'b1;
			end
			c6502eu_pkg::OP_LDX: begin
				ex_res.x = m; ex_res.p = c6502eu_pkg::set_nz(p_q, m); ex_res.hint = 1'b1;
			end
			c6502eu_pkg::OP_LDY: begin
				ex_res.y = m; ex_res.p = c6502eu_pkg::set_nz(p_q, m); ex_res.hint = 1'b1;
			end
			c6502eu_pkg::OP_STA: begin ex_res.we = 1'b1; ex_res.wd = a_q; end
			c6502eu_pkg::OP_STX: begin ex_res.we = 1'b1; ex_res.wd = x_q; end
			c6502eu_pkg::OP_STY: begin ex_res.we = 1'b1; ex_res.wd = y_q; end
			c6502eu_pkg::OP_TAX: begin ex_res.x = a_q; ex_res.p = c6502eu_pkg::set_nz(p_q, a_q); end
			c6502eu_pkg::OP_TXA: begin ex_res.a = x_q; ex_res.p = c6502eu_pkg::set_nz(p_q, x_q); end
			c6502eu_pkg::OP_TAY: begin ex_res.y = a_q; ex_res.p = c6502eu_pkg::set_nz(p_q, a_q); end
			c6502eu_pkg::OP_TYA: begin ex_res.a = y_q; ex_res.p = c6502eu_pkg::set_nz(p_q, y_q); end
			c6502eu_pkg::OP_TSX: begin ex_res.x = s_q; ex_res.p = c6502eu_pkg::set_nz(p_q, s_q); end
			c6502eu_pkg::OP_TXS: ex_res.s = x_q;
			c6502eu_pkg::OP_INC, c6502eu_pkg::OP_DEC: begin
				r = (op == c6502eu_pkg::OP_INC) ? m + 8'd1 : m - 8'd1;
				ex_res.we = 1'b1;
				ex_res.wd = r;
				ex_res.p  = c6502eu_pkg::set_nz(p_q, r);
			end
			c6502eu_pkg::OP_INX, c6502eu_pkg::OP_DEX: begin
				r = (op == c6502eu_pkg::OP_INX) ? x_q + 8'd1 : x_q - 8'd1;
				ex_res.x = r;
				ex_res.p = c6502eu_pkg::set_nz(p_q, r);
			end
			c6502eu_pkg::OP_INY, c6502eu_pkg::OP_DEY: begin
				r = (op == c6502eu_pkg::OP_INY) ? y_q + 8'd1 : y_q - 8'd1;
				ex_res.y = r;
				ex_res.p = c6502eu_pkg::set_nz(p_q, r);
			end
			c6502eu_pkg::OP_BCS: begin br = 1'b1; take =  p_q[c6502eu_pkg::FL_C]; end
			c6502eu_pkg::OP_BCC: begin br = 1'b1; take = !p_q[c6502eu_pkg::FL_C]; end
			c6502eu_pkg::OP_BEQ: begin br = 1'b1; take =  p_q[c6502eu_pkg::FL_Z]; end
			c6502eu_pkg::OP_BNE: begin br = 1'b1; take = !p_q[c6502eu_pkg::FL_Z]; end
			c6502eu_pkg::OP_BMI: begin br = 1'b1; take =  p_q[c6502eu_pkg::FL_N]; end
			c6502eu_pkg::OP_BPL: begin br = 1'b1; take = !p_q[c6502eu_pkg::FL_N]; end
			c6502eu_pkg::OP_BVS: begin br = 1'b1; take =  p_q[c6502eu_pkg::FL_V]; end
			c6502eu_pkg::OP_BVC: begin br = 1'b1; take = !p_q[c6502eu_pkg::FL_V]; end
			c6502eu_pkg::OP_JMP: ex_res.pc = effective_addr;
			c6502eu_pkg::OP_CLC: ex_res.p[c6502eu_pkg::FL_C] = 1'b0;
			c6502eu_pkg::OP_CLD: ex_res.p[c6502eu_pkg::FL_D] = 1'b0;
			c6502eu_pkg::OP_CLI: ex_res.p[c6502eu_pkg::FL_I] = 1'b0;
			c6502eu_pkg::OP_CLV: ex_res.p[c6502eu_pkg::FL_V] = 1'b0;
			c6502eu_pkg::OP_SEC: ex_res.p[c6502eu_pkg::FL_C] = 1'b1;
			c6502eu_pkg::OP_SED: ex_res.p[c6502eu_pkg::FL_D] = 1'b1;
			c6502eu_pkg::OP_SEI: ex_res.p[c6502eu_pkg::FL_I] = 1'b1;
			c6502eu_pkg::OP_NOP: begin
				// absolute,X NOPs may cross a page
				ex_res.hint = (raw_opcode == 8'h1C) || (raw_opcode == 8'h3C) ||
					(raw_opcode == 8'h5C) || (raw_opcode == 8'h7C) ||
					(raw_opcode == 8'hDC) || (raw_opcode == 8'hFC);
			end
			default: ;
		endcase
		if (br && take) begin
			ex_res.pc    = dest;
			ex_res.extra = (dest[15:8] != next_pc[15:8]) ? 2'd2 : 2'd1;
		end
		if (!ex_res.we) begin
			ex_res.wa = 16'h0000;
		end else begin
			ex_res.wa = effective_addr;
		end
	end

	// stack sequencer: one RAM access per cycle
	logic [15:0] pc_m1, pc_p1;
	assign pc_m1   = pc_q - 16'd1;
	assign pc_p1   = pc_q + 16'd1;
	assign rd_byte = rvld_q ? ram_rdata : 8'h00;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = s_q - {6'd0, step_q};
		ram_wdata = 8'h00;
		ram_re    = 1'b0;
		ram_raddr = s_q + 8'd1 + {6'd0, step_q};
		fin       = 1'b0;
		if (state_q == c6502eu_pkg::ST_PUSH) begin
			ram_we = 1'b1;
			fin    = (step_q == nacc_q - 2'd1);
			case (op_q)
				c6502eu_pkg::OP_PHA: ram_wdata = a_q;
				c6502eu_pkg::OP_PHP: ram_wdata = p_q | c6502eu_pkg::PUSH_BU;
				c6502eu_pkg::OP_JSR: ram_wdata = (step_q == 2'd0) ? pc_m1[15:8] : pc_m1[7:0];
				c6502eu_pkg::OP_BRK: begin
					if (step_q == 2'd0) begin
						ram_wdata = pc_p1[15:8];
					end else if (step_q == 2'd1) begin
						ram_wdata = pc_p1[7:0];
					end else begin
						ram_wdata = p_q | c6502eu_pkg::PUSH_BU;
					end
				end
				default: ram_wdata = 8'h00;
			endcase
		end else if (state_q == c6502eu_pkg::ST_PULL) begin
			ram_re = (step_q != nacc_q);
			fin    = (step_q == nacc_q);
		end
	end

	// final register update of a stack word
	always_comb begin
		st_res    = '0;
		st_res.pc = pc_q;
		st_res.a  = a_q;
		st_res.x  = x_q;
		st_res.y  = y_q;
		st_res.p  = p_q;
		st_res.s  = s_q;
		case (op_q)
			c6502eu_pkg::OP_PHA, c6502eu_pkg::OP_PHP: st_res.s = s_q - 8'd1;
			c6502eu_pkg::OP_JSR: begin
				st_res.s  = s_q - 8'd2;
				st_res.pc = ea_q;
			end
			c6502eu_pkg::OP_BRK: begin
				st_res.s  = s_q - 8'd3;
				st_res.pc = irq_q;
				st_res.p  = p_q;
				st_res.p[c6502eu_pkg::FL_I] = 1'b1;
				st_res.p[c6502eu_pkg::FL_B] = 1'b0;
			end
			c6502eu_pkg::OP_PLA: begin
				st_res.s = s_q + 8'd1;
				st_res.a = rd_byte;
				st_res.p = c6502eu_pkg::set_nz(p_q, rd_byte);
			end
			c6502eu_pkg::OP_PLP: begin
				st_res.s = s_q + 8'd1;
				st_res.p = rd_byte;
				st_res.p[c6502eu_pkg::FL_B] = 1'b0;
				st_res.p[c6502eu_pkg::FL_U] = 1'b1;
			end
			c6502eu_pkg::OP_RTS: begin
				st_res.s  = s_q + 8'd2;
				st_res.pc = {rd_byte, b0_q} + 16'd1;
			end
			c6502eu_pkg::OP_RTI: begin
				st_res.s  = s_q + 8'd3;
				st_res.pc = {rd_byte, b1_q};
				st_res.p  = b0_q;
				st_res.p[c6502eu_pkg::FL_B] = 1'b0;
				st_res.p[c6502eu_pkg::FL_U] = 1'b1;
			end
			default: ;
		endcase
	end

	assign load     = (in_acc && !in_is_stack) || fin;
	assign load_res = fin ? st_res : ex_res;

	c6502eu_ram #(
		.WIDTH(8),
		.DEPTH(c6502eu_pkg::STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q      <= 8'h00;
			x_q      <= 8'h00;
			y_q      <= 8'h00;
			p_q      <= c6502eu_pkg::FLAGS_RESET;
			s_q      <= c6502eu_pkg::SP_RESET;
			irq_q    <= 16'h0000;
			state_q  <= c6502eu_pkg::ST_IDLE;
			step_q   <= 2'd0;
			ovalid_q <= 1'b0;
			vld_q    <= '0;
			rvld_q   <= 1'b0;
		end else begin
			if (irq_vector_we) begin
				irq_q <= irq_vector_wdata;
			end
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			if (ram_re) begin
				rvld_q <= vld_q[ram_raddr];
			end
			if (load) begin
				a_q <= load_res.a;
				x_q <= load_res.x;
				y_q <= load_res.y;
				p_q <= load_res.p;
				s_q <= load_res.s;
			end
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				c6502eu_pkg::ST_IDLE: begin
					step_q <= 2'd0;
					if (in_acc && in_is_stack) begin
						state_q <= in_is_push ? c6502eu_pkg::ST_PUSH : c6502eu_pkg::ST_PULL;
					end
				end
				c6502eu_pkg::ST_PUSH, c6502eu_pkg::ST_PULL: begin
					if (fin) begin
						state_q <= c6502eu_pkg::ST_IDLE;
						step_q  <= 2'd0;
					end else begin
						step_q <= step_q + 2'd1;
					end
				end
				default: state_q <= c6502eu_pkg::ST_IDLE;
			endcase
		end
	end

	// item latch and pulled bytes
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= op;
			ea_q   <= effective_addr;
			pc_q   <= next_pc;
			nacc_q <= in_nacc;
		end
		if (state_q == c6502eu_pkg::ST_PULL) begin
			if (step_q == 2'd1) begin
				b0_q <= rd_byte;
			end
			if (step_q == 2'd2) begin
				b1_q <= rd_byte;
			end
		end
		if (load) begin
			out_q <= load_res;
		end
	end

	assign out_valid       = ovalid_q;
	assign write_enable    = out_q.we;
	assign write_addr      = out_q.wa;
	assign write_data      = out_q.wd;
	assign new_pc          = out_q.pc;
	assign accumulator_out = out_q.a;
	assign index_x_out     = out_q.x;
	assign index_y_out     = out_q.y;
	assign status_out      = out_q.p;
	assign stack_ptr_out   = out_q.s;
	assign extra_cycles    = out_q.extra;
	assign may_add_cycle   = out_q.hint;

endmodule

@@ tb/cpu6502_execute_unit_test.sv @@
// Testbench for the 6502 execute unit: directed table, then random instruction mix.
// Depends on c6502eu_pkg and the cpu6502_execute_unit RTL.
module cpu6502_execute_unit_test;

	localparam int N_RANDOM  = 2000;
	localparam int WATCHDOG  = 20000;
	localparam int IDLE_PCT  = 29;
	localparam int DRAIN_CYC = 20;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [5:0]  op;
	logic [7:0]  operand, raw_opcode;
	logic [15:0] effective_addr, branch_offset, next_pc;
	logic        implied_mode;
	logic        write_enable, may_add_cycle;
	logic [15:0] write_addr, new_pc;
	logic [7:0]  write_data, accumulator_out, index_x_out, index_y_out;
	logic [7:0]  status_out, stack_ptr_out;
	logic [1:0]  extra_cycles;
	logic        irq_vector_we;
	logic [15:0] irq_vector_wdata;

	cpu6502_execute_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .operand(operand),
		.effective_addr(effective_addr), .branch_offset(branch_offset),
		.implied_mode(implied_mode), .raw_opcode(raw_opcode), .next_pc(next_pc),
		.out_valid(out_valid), .out_stall(out_stall),
		.write_enable(write_enable), .write_addr(write_addr), .write_data(write_data),
		.new_pc(new_pc), .accumulator_out(accumulator_out), .index_x_out(index_x_out),
		.index_y_out(index_y_out), .status_out(status_out),
		.stack_ptr_out(stack_ptr_out), .extra_cycles(extra_cycles),
		.may_add_cycle(may_add_cycle),
		.irq_vector_we(irq_vector_we), .irq_vector_wdata(irq_vector_wdata)
	);

	typedef struct packed {
		logic [5:0]  op;
		logic [7:0]  operand;
		logic [15:0] ea;
		logic [15:0] off;
		logic        imp;
		logic [7:0]  opc;
		logic [15:0] npc;
	} instr_t;

	// directed row: instruction plus an optional hand-typed result
	typedef struct {
		instr_t               ins;
		bit                   typed;
		c6502eu_pkg::result_t res;
	} row_t;

	// predictor copy of the architectural state
	logic [7:0]  m_a, m_x, m_y, m_p, m_s;
	logic [7:0]  m_stack [256];
	logic [15:0] m_vec;

	c6502eu_pkg::result_t expected_q [$];
	int      n_errors, n_accepted, n_results, idle_cnt;
	bit      no_idle;     // long stretch without any idling
	int      n_taken_br, n_pagecross;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
		nz = p;
		nz[c6502eu_pkg::FL_Z] = (v == 8'h00);
		nz[c6502eu_pkg::FL_N] = v[7];
	endfunction

	// execute one instruction on the predictor state
	task automatic execute_instr(input instr_t i, output c6502eu_pkg::result_t r);
		logic [7:0]  m, v, res8, lo, hi;
		logic [8:0]  sum;
		logic [15:0] pc, dest;
		logic        br, take, we;
		logic [7:0]  wd;
		logic [1:0]  extra;
		logic        hint;
		m = i.imp ? m_a : i.operand;
		pc = i.npc;
		br = 0; take = 0; we = 0; wd = 0; extra = 0; hint = 0;
		case (i.op)
			c6502eu_pkg::OP_ADC, c6502eu_pkg::OP_SBC: begin
				v = (i.op == c6502eu_pkg::OP_SBC) ? ~m : m;
				sum = {1'b0, m_a} + {1'b0, v} + {8'b0, m_p[c6502eu_pkg::FL_C]};
				m_p[c6502eu_pkg::FL_C] = sum[8];
				m_p[c6502eu_pkg::FL_V] = (sum[7] ^ m_a[7]) & (sum[7] ^ v[7]);
				m_a = sum[7:0];
				m_p = nz(m_p, m_a);
				hint = 1;
			end
			c6502eu_pkg::OP_AND: begin m_a = m_a & m; m_p = nz(m_p, m_a); hint = 1; end
			c6502eu_pkg::OP_EOR: begin m_a = m_a ^ m; m_p = nz(m_p, m_a); hint = 1; end
			c6502eu_pkg::OP_ORA: begin m_a = m_a | m; m_p = nz(m_p, m_a); hint = 1; end
			c6502eu_pkg::OP_BIT: begin
				m_p[c6502eu_pkg::FL_Z] = ((m_a & m) == 8'h00);
				m_p[c6502eu_pkg::FL_N] = m[7];
				m_p[c6502eu_pkg::FL_V] = m[6];
			end
			c6502eu_pkg::OP_ASL, c6502eu_pkg::OP_LSR,
			c6502eu_pkg::OP_ROL, c6502eu_pkg::OP_ROR: begin
				case (i.op)
					c6502eu_pkg::OP_ASL: begin
						res8 = {m[6:0], 1'b0}; m_p[c6502eu_pkg::FL_C] = m[7];
					end
					c6502eu_pkg::OP_LSR: begin
						res8 = {1'b0, m[7:1]}; m_p[c6502eu_pkg::FL_C] = m[0];
					end
					c6502eu_pkg::OP_ROL: begin
						res8 = {m[6:0], m_p[c6502eu_pkg::FL_C]}; m_p[c6502eu_pkg::FL_C] = m[7];
					end
					default: begin
						res8 = {m_p[c6502eu_pkg::FL_C], m[7:1]}; m_p[c6502eu_pkg::FL_C] = m[0];
					end
				endcase
				m_p = nz(m_p, res8);
				if (i.imp) m_a = res8;
				else begin we = 1; wd = res8; end
			end
			c6502eu_pkg::OP_CMP, c6502eu_pkg::OP_CPX, c6502eu_pkg::OP_CPY: begin
				v = (i.op == c6502eu_pkg::OP_CMP) ? m_a :
					(i.op == c6502eu_pkg::OP_CPX) ? m_x : m_y;
				m_p[c6502eu_pkg::FL_C] = (v >= m);
				m_p = nz(m_p, v - m);
				hint = (i.op == c6502eu_pkg::OP_CMP);
			end
			c6502eu_pkg::OP_LDA: begin m_a = m; m_p = nz(m_p, m); hint = 1; end
			c6502eu_pkg::OP_LDX: begin m_x = m; m_p = nz(m_p, m); hint = 1; end
			c6502eu_pkg::OP_LDY: begin m_y = m; m_p = nz(m_p, m); hint = 1; end
			c6502eu_pkg::OP_STA: begin we = 1; wd = m_a; end
			c6502eu_pkg::OP_STX: begin we = 1; wd = m_x; end
			c6502eu_pkg::OP_STY: begin we = 1; wd = m_y; end
			c6502eu_pkg::OP_TAX: begin m_x = m_a; m_p = nz(m_p, m_x); end
			c6502eu_pkg::OP_TXA: begin m_a = m_x; m_p = nz(m_p, m_a); end
			c6502eu_pkg::OP_TAY: begin m_y = m_a; m_p = nz(m_p, m_y); end
			c6502eu_pkg::OP_TYA: begin m_a = m_y; m_p = nz(m_p, m_a); end
			c6502eu_pkg::OP_TSX: begin m_x = m_s; m_p = nz(m_p, m_x); end
			c6502eu_pkg::OP_TXS: m_s = m_x;
			c6502eu_pkg::OP_INC: begin wd = m + 8'd1; we = 1; m_p = nz(m_p, wd); end
			c6502eu_pkg::OP_DEC: begin wd = m - 8'd1; we = 1; m_p = nz(m_p, wd); end
			c6502eu_pkg::OP_INX: begin m_x = m_x + 8'd1; m_p = nz(m_p, m_x); end
			c6502eu_pkg::OP_DEX: begin m_x = m_x - 8'd1; m_p = nz(m_p, m_x); end
			c6502eu_pkg::OP_INY: begin m_y = m_y + 8'd1; m_p = nz(m_p, m_y); end
			c6502eu_pkg::OP_DEY: begin m_y = m_y - 8'd1; m_p = nz(m_p, m_y); end
			c6502eu_pkg::OP_BCS: begin br = 1; take = m_p[c6502eu_pkg::FL_C]; end
			c6502eu_pkg::OP_BCC: begin br = 1; take = !m_p[c6502eu_pkg::FL_C]; end
			c6502eu_pkg::OP_BEQ: begin br = 1; take = m_p[c6502eu_pkg::FL_Z]; end
			c6502eu_pkg::OP_BNE: begin br = 1; take = !m_p[c6502eu_pkg::FL_Z]; end
			c6502eu_pkg::OP_BMI: begin br = 1; take = m_p[c6502eu_pkg::FL_N]; end
			c6502eu_pkg::OP_BPL: begin br = 1; take = !m_p[c6502eu_pkg::FL_N]; end
			c6502eu_pkg::OP_BVS: begin br = 1; take = m_p[c6502eu_pkg::FL_V]; end
			c6502eu_pkg::OP_BVC: begin br = 1; take = !m_p[c6502eu_pkg::FL_V]; end
			c6502eu_pkg::OP_JMP: pc = i.ea;
			c6502eu_pkg::OP_JSR: begin
				pc = pc - 16'd1;
				m_stack[m_s] = pc[15:8]; m_s = m_s - 8'd1;
				m_stack[m_s] = pc[7:0];  m_s = m_s - 8'd1;
				pc = i.ea;
			end
			c6502eu_pkg::OP_RTS: begin
				m_s = m_s + 8'd1; lo = m_stack[m_s];
				m_s = m_s + 8'd1; hi = m_stack[m_s];
				pc = {hi, lo} + 16'd1;
			end
			c6502eu_pkg::OP_PHA: begin m_stack[m_s] = m_a; m_s = m_s - 8'd1; end
			c6502eu_pkg::OP_PHP: begin
				m_stack[m_s] = m_p | c6502eu_pkg::PUSH_BU; m_s = m_s - 8'd1;
			end
			c6502eu_pkg::OP_PLA: begin
				m_s = m_s + 8'd1; m_a = m_stack[m_s]; m_p = nz(m_p, m_a);
			end
			c6502eu_pkg::OP_PLP: begin
				m_s = m_s + 8'd1;
				m_p = m_stack[m_s];
				m_p[c6502eu_pkg::FL_B] = 0; m_p[c6502eu_pkg::FL_U] = 1;
			end
			c6502eu_pkg::OP_CLC: m_p[c6502eu_pkg::FL_C] = 0;
			c6502eu_pkg::OP_CLD: m_p[c6502eu_pkg::FL_D] = 0;
			c6502eu_pkg::OP_CLI: m_p[c6502eu_pkg::FL_I] = 0;
			c6502eu_pkg::OP_CLV: m_p[c6502eu_pkg::FL_V] = 0;
			c6502eu_pkg::OP_SEC: m_p[c6502eu_pkg::FL_C] = 1;
			c6502eu_pkg::OP_SED: m_p[c6502eu_pkg::FL_D] = 1;
			c6502eu_pkg::OP_SEI: m_p[c6502eu_pkg::FL_I] = 1;
			c6502eu_pkg::OP_BRK: begin
				pc = pc + 16'd1;
				m_stack[m_s] = pc[15:8]; m_s = m_s - 8'd1;
				m_stack[m_s] = pc[7:0];  m_s = m_s - 8'd1;
				m_stack[m_s] = m_p | c6502eu_pkg::PUSH_BU; m_s = m_s - 8'd1;
				m_p[c6502eu_pkg::FL_I] = 1; m_p[c6502eu_pkg::FL_B] = 0;
				pc = m_vec;
			end
			c6502eu_pkg::OP_RTI: begin
				m_s = m_s + 8'd1;
				m_p = m_stack[m_s];
				m_p[c6502eu_pkg::FL_B] = 0; m_p[c6502eu_pkg::FL_U] = 1;
				m_s = m_s + 8'd1; lo = m_stack[m_s];
				m_s = m_s + 8'd1; hi = m_stack[m_s];
				pc = {hi, lo};
			end
			c6502eu_pkg::OP_NOP:
				hint = (i.opc inside {8'h1C, 8'h3C, 8'h5C, 8'h7C, 8'hDC, 8'hFC});
			default: ;  // unused codes behave as NOP with no hint
		endcase
		if (br && take) begin
			dest = pc + i.off;
			extra = (dest[15:8] != pc[15:8]) ? 2'd2 : 2'd1;
			n_taken_br++;
			if (extra == 2) n_pagecross++;
			pc = dest;
		end
		r.we = we;
		r.wa = we ? i.ea : 16'h0;
		r.wd = we ? wd : 8'h0;
		r.pc = pc;
		r.a = m_a; r.x = m_x; r.y = m_y; r.p = m_p; r.s = m_s;
		r.extra = extra;
		r.hint = hint;
	endtask

	// random idle decision: off during the quiet stretch
	function automatic bit idle_now();
		return !no_idle && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// stall side: random backpressure, re-decided every edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= idle_now();
	end

	// result checker
	always @(posedge clk) begin
		c6502eu_pkg::result_t got, exp_r;
		if (arst_n && out_valid && !out_stall) begin
			got = '{write_enable, write_addr, write_data, new_pc, accumulator_out,
				index_x_out, index_y_out, status_out, stack_ptr_out,
				extra_cycles, may_add_cycle};
			n_results++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected word, actual %h", $time, got);
				n_errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (got.we !== exp_r.we || got.wa !== exp_r.wa || got.wd !== exp_r.wd)
					$display("%0t: write exp %b/%h/%h act %b/%h/%h", $time,
						exp_r.we, exp_r.wa, exp_r.wd, got.we, got.wa, got.wd);
				if (got.pc !== exp_r.pc)
					$display("%0t: new_pc exp %h act %h", $time, exp_r.pc, got.pc);
				if (got.a !== exp_r.a || got.x !== exp_r.x || got.y !== exp_r.y)
					$display("%0t: a/x/y exp %h/%h/%h act %h/%h/%h", $time,
						exp_r.a, exp_r.x, exp_r.y, got.a, got.x, got.y);
				if (got.p !== exp_r.p)
					$display("%0t: status exp %h act %h", $time, exp_r.p, got.p);
				if (got.s !== exp_r.s)
					$display("%0t: sp exp %h act %h", $time, exp_r.s, got.s);
				if (got.extra !== exp_r.extra || got.hint !== exp_r.hint)
					$display("%0t: extra/hint exp %0d/%b act %0d/%b", $time,
						exp_r.extra, exp_r.hint, got.extra, got.hint);
				if (got !== exp_r) n_errors++;
			end
		end
	end

	// watchdog: cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("%0t: watchdog expired, %0d words pending", $time, expected_q.size());
			$display("FAIL");
			$finish;
		end
	end

	// drive one instruction and predict it at acceptance; valid stays up
	// into the next word unless an idle cycle comes first
	task automatic send_instr(input instr_t i, input bit typed,
			input c6502eu_pkg::result_t tr);
		c6502eu_pkg::result_t r;
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		op <= i.op; operand <= i.operand; effective_addr <= i.ea;
		branch_offset <= i.off; implied_mode <= i.imp; raw_opcode <= i.opc;
		next_pc <= i.npc;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		execute_instr(i, r);
		if (typed && r !== tr) begin
			$display("%0t: typed row disagrees, table %h predictor %h", $time, tr, r);
			n_errors++;
		end
		expected_q.push_back(typed ? tr : r);
		n_accepted++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_vector(input logic [15:0] v);
		irq_vector_we <= 1'b1;
		irq_vector_wdata <= v;
		@(posedge clk);
		irq_vector_we <= 1'b0;
		m_vec = v;
	endtask

	function automatic instr_t mk(input logic [5:0] o, input logic [7:0] d,
			input logic [15:0] ea, input logic [15:0] off, input logic imp,
			input logic [7:0] opc, input logic [15:0] npc);
		instr_t i;
		i = '{o, d, ea, off, imp, opc, npc};
		return i;
	endfunction

	function automatic instr_t rand_instr(input logic [5:0] o);
		instr_t i;
		i.op = o;
		i.operand = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
			: 8'($urandom);
		i.ea = 16'($urandom);
		// mostly short offsets, some far ones for page crossings
		i.off = $urandom_range(3) ? 16'($signed(8'($urandom))) : 16'($urandom);
		i.imp = 1'($urandom_range(1));
		i.opc = $urandom_range(3) ? 8'($urandom)
			: {$urandom_range(7) == 4 ? 3'd6 : 3'($urandom_range(7)), 5'h1C};
		i.npc = 16'($urandom);
		return i;
	endfunction

	row_t rows [$];

	initial begin
		row_t rw;
		c6502eu_pkg::result_t z;
		instr_t  ri;
		int k, sel;
		logic [5:0] o;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = '0; operand = '0; effective_addr = '0; branch_offset = '0;
		implied_mode = 1'b0; raw_opcode = '0; next_pc = '0;
		irq_vector_we = 1'b0; irq_vector_wdata = '0;
		n_accepted = 0;
		n_taken_br = 0; n_pagecross = 0;
		no_idle = 0;
		m_a = 0; m_x = 0; m_y = 0; m_vec = 0;
		m_p = c6502eu_pkg::FLAGS_RESET; m_s = c6502eu_pkg::SP_RESET;
		for (k = 0; k < 256; k++) m_stack[k] = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: NOP after reset and a few typed extremes
		z = '{1'b0, 16'h0, 8'h0, 16'h1234, 8'h0, 8'h0, 8'h0, c6502eu_pkg::FLAGS_RESET,
			c6502eu_pkg::SP_RESET, 2'd0, 1'b0};
		rows.push_back('{mk(c6502eu_pkg::OP_NOP, 8'h00, 16'h0, 16'h0, 1'b1, 8'hEA,
			16'h1234), 1, z});
		z.pc = 16'hFFFF; z.hint = 1;
		rows.push_back('{mk(c6502eu_pkg::OP_NOP, 8'h00, 16'h0, 16'h0, 1'b1, 8'hFC,
			16'hFFFF), 1, z});
		z.pc = 16'h0000; z.hint = 0;
		rows.push_back('{mk(6'd63, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'h1C, 16'h0000), 1, z});
		// LDA #FF: N set, hint
		z = '{1'b0, 16'h0, 8'h0, 16'h0002, 8'hFF, 8'h0, 8'h0, 8'hA0,
			c6502eu_pkg::SP_RESET, 2'd0, 1'b1};
		rows.push_back('{mk(c6502eu_pkg::OP_LDA, 8'hFF, 16'h0, 16'h0, 1'b0, 8'hA9,
			16'h0002), 1, z});
		// ADC FF+01 carries to zero
		rows.push_back('{mk(c6502eu_pkg::OP_ADC, 8'h01, 16'h0, 16'h0, 1'b0, 8'h69,
			16'h0004), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_ADC, 8'h7F, 16'h0, 16'h0, 1'b0, 8'h69,
			16'h0006), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_SBC, 8'h80, 16'h0, 16'h0, 1'b0, 8'hE9,
			16'h0008), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_STA, 8'h00, 16'hFFFF, 16'h0, 1'b0, 8'h8D,
			16'h000B), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_ASL, 8'h00, 16'h0, 16'h0, 1'b1, 8'h0A,
			16'h000C), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_ROR, 8'h81, 16'h8000, 16'h0, 1'b0, 8'h6E,
			16'h000F), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_INC, 8'hFF, 16'h0000, 16'h0, 1'b1, 8'hEE,
			16'h0012), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_BIT, 8'hC0, 16'h0, 16'h0, 1'b0, 8'h2C,
			16'h0015), 0, z});
		// branches: only BVS is taken, crossing a page forward; BEQ and BCC fall through
		rows.push_back('{mk(c6502eu_pkg::OP_BEQ, 8'h00, 16'h0, 16'hFF80, 1'b0, 8'hF0,
			16'h0217), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_BVS, 8'h00, 16'h0, 16'h007F, 1'b0, 8'h70,
			16'h02F0), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_BCC, 8'h00, 16'h0, 16'h0010, 1'b0, 8'h90,
			16'h0300), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_JSR, 8'h00, 16'hC000, 16'h0, 1'b0, 8'h20,
			16'h8003), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_PHP, 8'h00, 16'h0, 16'h0, 1'b1, 8'h08,
			16'hC001), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_PLP, 8'h00, 16'h0, 16'h0, 1'b1, 8'h28,
			16'hC002), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_RTS, 8'h00, 16'h0, 16'h0, 1'b1, 8'h60,
			16'hC003), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_BRK, 8'h00, 16'h0, 16'h0, 1'b1, 8'h00,
			16'hFFFF), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_RTI, 8'h00, 16'h0, 16'h0, 1'b1, 8'h40,
			16'h0000), 0, z});
		// stack wrap: SP to 00 then push and pull across the boundary
		rows.push_back('{mk(c6502eu_pkg::OP_LDX, 8'h00, 16'h0, 16'h0, 1'b0, 8'hA2,
			16'h0002), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_TXS, 8'h00, 16'h0, 16'h0, 1'b1, 8'h9A,
			16'h0003), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_PHA, 8'h00, 16'h0, 16'h0, 1'b1, 8'h48,
			16'h0004), 0, z});
		rows.push_back('{mk(c6502eu_pkg::OP_PLA, 8'h00, 16'h0, 16'h0, 1'b1, 8'h68,
			16'h0005), 0, z});

		foreach (rows[j]) send_instr(rows[j].ins, rows[j].typed, rows[j].res);
		drain();

		// random phases, each under its own BRK vector incl. both extremes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_vector(16'hFFFF);
				1: write_vector(16'h0000);
				default: write_vector(16'($urandom));
			endcase
			for (k = 0; k < N_RANDOM / 4; k++) begin
				no_idle = (ph == 2) && (k >= 100) && (k < 300);
				sel = $urandom_range(99);
				if (sel < 12) o = c6502eu_pkg::OP_BCS + 6'($urandom_range(7));
				else if (sel < 24) o = c6502eu_pkg::OP_JSR + 6'($urandom_range(5));
				else if (sel < 28) o = c6502eu_pkg::OP_BRK + 6'($urandom_range(1));
				else if (sel < 31) o = 6'($urandom_range(63, 56));
				else o = 6'($urandom_range(55));
				send_instr(rand_instr(o), 0, z);
			end
			no_idle = 0;
			drain();
		end

		$display("Ran %0d words (%0d taken branches, %0d page crossings), %0d results.",
			n_accepted, n_taken_br, n_pagecross, n_results);
		$display("Covered all 64 op codes, four BRK vectors, stack wrap and random stalls.");
		if (n_errors == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("FAIL");
		end
		$finish;
	end

endmodule
